/* rtl/chi_square_weighted_score_assert.svh */
// Assertion macros for the chi-square weighted score block.
// Used by the port checker; no other dependencies.
`ifndef CHI_SQUARE_WEIGHTED_SCORE_ASSERT_SVH
`define CHI_SQUARE_WEIGHTED_SCORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define CSWS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csws same-cycle check failed");

// Next-cycle implication, checked out of reset
`define CSWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csws next-cycle check failed");

`endif

/* rtl/csws_pkg.sv */
// Shared types and constants of the chi-square weighted score block.
// No dependencies.
package csws_pkg;

    localparam int BIN_W      = 16;   // histogram bin
    localparam int SUM_W      = 17;   // a + b
    localparam int SQ_W       = 32;   // (a - b)^2
    localparam int ACC_W      = 32;   // channel accumulator
    localparam int WGT_W      = 24;   // signed weight
    localparam int OUT_W      = 48;   // decision value
    localparam int PROD_W     = 57;   // weight * {0, accumulator}
    localparam int MAC_W      = 59;   // sum of up to four products
    localparam int CH_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_WEIGHTS = 4;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_LUM      = 3'd0,
        REG_WEIGHT_CHROMA_A = 3'd1,
        REG_WEIGHT_CHROMA_B = 3'd2,
        REG_WEIGHT_TEXTURE  = 3'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_WEIGH,
        ST_FLUSH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clr;
        logic en;
    } mac_ctrl_t;

endpackage

/* rtl/chi_square_weighted_score.sv */
// Top level of the chi-square weighted score block: sequencer, channel
// accumulators, weight registers. Depends on csws_pkg, csws_div, csws_mac.
//
//   port group          direction  transfer
//   start/bin fields    in         start high while busy low
//   cfg_write/index/dat in         cfg_write high, any cycle the block is idle
//   done/pair_score     out        done high for one cycle, no stall
//
// A bin with a nonzero sum and an in-range channel goes through the divider,
// one quotient bit per cycle; any other bin without last leaves the block idle.
// A last bin also weighs every channel in turn through the shared multiplier.
// Reset clears accumulators, weights and control; nothing can stall the output.
module chi_square_weighted_score #(
    parameter int NUM_CHANNELS = 4,
    parameter int FRAC_BITS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [csws_pkg::BIN_W-1:0]        bin_first,
    input  logic [csws_pkg::BIN_W-1:0]        bin_second,
    input  logic [csws_pkg::CH_W-1:0]         channel,
    input  logic                              last_bin,
    input  logic                              cfg_write,
    input  logic [csws_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [csws_pkg::WGT_W-1:0]        cfg_data,
    output logic                              done,
    output logic signed [csws_pkg::OUT_W-1:0] pair_score
);
    import csws_pkg::*;

    localparam int QW  = BIN_W + FRAC_BITS;
    localparam int SW  = ((QW > ACC_W) ? QW : ACC_W) + 1;
    localparam int CIW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [3:0]     NUM_CH    = 4'(NUM_CHANNELS);
    localparam logic [CIW-1:0] LAST_CH   = CIW'(NUM_CHANNELS - 1);
    localparam int             HI_W      = MAC_W - OUT_W + 1;

    state_t state_reg, state_next;

    logic [ACC_W-1:0]        sums_reg [NUM_CHANNELS];
    logic signed [WGT_W-1:0] weight_reg [NUM_WEIGHTS];
    logic [CH_W-1:0]         ch_reg;
    logic                    last_reg;
    logic [CIW-1:0]          wc_reg;
    logic                    done_reg;
    logic signed [OUT_W-1:0] decision_reg;

    logic                    accept;
    logic [SUM_W-1:0]        total;
    logic [BIN_W-1:0]        diff;
    logic                    ch_ok;
    logic                    go_div;
    logic                    div_start;
    logic                    div_done;
    logic [QW-1:0]           term;
    logic                    sum_upd;
    logic                    shift_out;
    logic                    out_load;
    logic [CIW-1:0]          ch_idx;
    logic [SW-1:0]           sum_wide;
    logic [ACC_W-1:0]        sum_sat;
    logic [2:0]              wsel;
    logic signed [WGT_W-1:0] weight_cur;
    mac_ctrl_t               mac_ctrl;
    logic signed [MAC_W-1:0] mac_acc;
    logic signed [MAC_W-1:0] score_shr;
    logic [HI_W-1:0]         score_hi;
    logic signed [OUT_W-1:0] score_sat;

    assign accept = start && (state_reg == ST_IDLE);
    assign total  = {1'b0, bin_first} + {1'b0, bin_second};
    assign diff   = (bin_first >= bin_second) ? (bin_first - bin_second)
                                              : (bin_second - bin_first);
    assign ch_ok  = {2'b0, channel} < NUM_CH;
    assign go_div = (total != '0) && ch_ok;

    csws_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .diff     (diff),
        .total    (total),
        .done     (div_done),
        .quotient (term)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (go_div)
                        state_next = ST_DIVIDE;
                    else if (last_bin)
                        state_next = ST_WEIGH;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                    state_next = last_reg ? ST_WEIGH : ST_IDLE;
            end
            ST_WEIGH:
            begin
                if (wc_reg == LAST_CH)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:  state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        div_start    = 1'b0;
        sum_upd      = 1'b0;
        shift_out    = 1'b0;
        out_load     = 1'b0;
        mac_ctrl.clr = 1'b0;
        mac_ctrl.en  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                div_start    = start && go_div;
                mac_ctrl.clr = 1'b1;
            end
            ST_DIVIDE: sum_upd = div_done;
            ST_WEIGH:
            begin
                shift_out   = 1'b1;
                mac_ctrl.en = 1'b1;
            end
            ST_FLUSH:  ;
            ST_FINISH: out_load = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg   <= channel;
            last_reg <= last_bin;
        end
    end

    // saturating accumulate of the bin term
    assign ch_idx   = CIW'(ch_reg);
    assign sum_wide = SW'(sums_reg[ch_idx]) + SW'(term);
    assign sum_sat  = (sum_wide > SW'(ACC_MAX)) ? ACC_MAX : sum_wide[ACC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
                sums_reg[i] <= '0;
        end
        else if (sum_upd)
            sums_reg[ch_idx] <= sum_sat;
        else if (shift_out)
        begin
            // feed channels to the multiplier in order, draining to zero
            for (int i = 0; i < NUM_CHANNELS - 1; i++)
                sums_reg[i] <= sums_reg[i+1];
            sums_reg[NUM_CHANNELS-1] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wc_reg <= '0;
        else if (shift_out)
            wc_reg <= wc_reg + 1'b1;
        else
            wc_reg <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WEIGHTS; i++)
                weight_reg[i] <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WEIGHT_LUM:      weight_reg[0] <= cfg_data;
                REG_WEIGHT_CHROMA_A: weight_reg[1] <= cfg_data;
                REG_WEIGHT_CHROMA_B: weight_reg[2] <= cfg_data;
                REG_WEIGHT_TEXTURE:  weight_reg[3] <= cfg_data;
                default:             ;
            endcase
        end
    end

    // channels past the weight registers count with weight zero
    assign wsel       = 3'(wc_reg);
    assign weight_cur = (wsel < 3'd4) ? weight_reg[wsel[1:0]] : '0;

    csws_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .weight (weight_cur),
        .value  (sums_reg[0]),
        .acc    (mac_acc)
    );

    // drop the fraction and halve with floor, then saturate to the output range
    assign score_shr = mac_acc >>> (FRAC_BITS + 1);
    assign score_hi  = score_shr[MAC_W-1:OUT_W-1];

    always_comb
    begin
        if (!score_hi[HI_W-1] && (|score_hi))
            score_sat = {1'b0, {(OUT_W-1){1'b1}}};
        else if (score_hi[HI_W-1] && !(&score_hi))
            score_sat = {1'b1, {(OUT_W-1){1'b0}}};
        else
            score_sat = score_shr[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= out_load;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            decision_reg <= score_sat;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign pair_score = decision_reg;

endmodule

/* rtl/csws_div.sv */
// Bin term unit: squares |a-b| once, then a restoring divider by a+b,
// one quotient bit per cycle. Depends on csws_pkg.
module csws_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [csws_pkg::BIN_W-1:0] diff,
    input  logic [csws_pkg::SUM_W-1:0] total,
    output logic                       done,
    output logic [FRAC_BITS+15:0]      quotient
);
    import csws_pkg::*;

    localparam int QW    = BIN_W + FRAC_BITS;
    localparam int CNT_W = $clog2(QW);

    logic [SQ_W-1:0]         sq_reg;
    logic [SUM_W-1:0]        den_reg;
    logic [SUM_W-1:0]        rem_reg;
    logic [QW-1:0]           quo_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    load_reg;
    logic                    run_reg;
    logic                    done_reg;

    logic [SQ_W+FRAC_BITS-1:0] num_wide;
    logic [SUM_W:0]            trial;
    logic [SUM_W:0]            trial_sub;
    logic                      fits;

    // (d^2 << F) / (s << 16) == ((d^2 << F) >> 16) / s
    assign num_wide  = {sq_reg, {FRAC_BITS{1'b0}}};
    assign trial     = {rem_reg, quo_reg[QW-1]};
    assign fits      = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= 1'b0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            load_reg <= start;
            done_reg <= 1'b0;
            if (load_reg)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(QW - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sq_reg  <= {16'b0, diff} * {16'b0, diff};
            den_reg <= total;
        end
        if (load_reg)
        begin
            quo_reg <= num_wide[SQ_W+FRAC_BITS-1:BIN_W];
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            // shift in the next dividend bit, subtract where the divisor fits
            rem_reg <= fits ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
            quo_reg <= {quo_reg[QW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/csws_mac.sv */
// Shared weighting unit: one signed multiply per cycle while enabled,
// registered, then accumulated into the weighted sum. Depends on csws_pkg.
module csws_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  csws_pkg::mac_ctrl_t               ctrl,
    input  logic signed [csws_pkg::WGT_W-1:0] weight,
    input  logic [csws_pkg::ACC_W-1:0]        value,
    output logic signed [csws_pkg::MAC_W-1:0] acc
);
    import csws_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     valid_reg;
    logic signed [MAC_W-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else if (ctrl.clr)
        begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            valid_reg <= ctrl.en;
            if (valid_reg)
                acc_reg <= acc_reg + MAC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
            prod_reg <= PROD_W'(weight * $signed({1'b0, value}));
    end

    assign acc = acc_reg;

endmodule

/* rtl/csws_checker.sv */
// Port-level checker for the chi-square weighted score block, bound to
// the top level. Depends on chi_square_weighted_score_assert.svh.
`include "chi_square_weighted_score_assert.svh"

module csws_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_bin,
    input logic done
);

    // a last bin always starts a scoring run
    `CSWS_ASSERT_NEXT(a_last_goes_busy, start && !busy && last_bin, busy)
    // the result shows only once the run is over
    `CSWS_ASSERT_NOW(a_done_not_busy, done, !busy)
    // one result per run, never back to back
    `CSWS_ASSERT_NEXT(a_done_single, done, !done)
    // a bin without last never gives a result right away
    `CSWS_ASSERT_NEXT(a_no_spurious, start && !busy && !last_bin, !done)

endmodule

bind chi_square_weighted_score csws_checker u_csws_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .last_bin (last_bin),
    .done     (done)
);

/* bench/csws_score_checker.sv */
`timescale 1ns / 100ps
// Checker for the chi-square weighted score block: tracks the channel sums and
// weights from the observed transfers, predicts each score, compares on done.
// Depends on csws_pkg.
module csws_score_checker #(
    parameter int NUM_CHANNELS = 4,
    parameter int FRAC_BITS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [csws_pkg::BIN_W-1:0]        bin_first,
    input  logic [csws_pkg::BIN_W-1:0]        bin_second,
    input  logic [csws_pkg::CH_W-1:0]         channel,
    input  logic                              last_bin,
    input  logic                              cfg_write,
    input  logic [csws_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [csws_pkg::WGT_W-1:0]        cfg_data,
    input  logic                              done,
    input  logic signed [csws_pkg::OUT_W-1:0] pair_score,
    output int                                mismatches,
    output int                                pending
);

    import csws_pkg::*;

    localparam longint SCORE_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint SCORE_MIN = -(longint'(1) <<< (OUT_W - 1));

    logic [ACC_W-1:0]        chan_acc [NUM_CHANNELS];
    logic signed [WGT_W-1:0] weight_reg [NUM_WEIGHTS];
    logic signed [OUT_W-1:0] score_queue [$];

    logic [BIN_W:0]          bin_sum;
    logic [BIN_W-1:0]        bin_diff;
    logic [63:0]             term;
    logic [63:0]             acc_next;
    longint                  weighted;
    longint                  floored;
    logic signed [OUT_W-1:0] want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
                chan_acc[c] = '0;
            for (int r = 0; r < NUM_WEIGHTS; r++)
                weight_reg[r] = '0;
            score_queue.delete();
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (score_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t: score %0d with none expected", $realtime, pair_score);
                end
                else
                begin
                    want = score_queue.pop_front();
                    if (pair_score !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%t: pair_score expected %0d, got %0d",
                                     $realtime, want, pair_score);
                    end
                end
            end

            if (cfg_write && cfg_index <= REG_WEIGHT_TEXTURE)
                weight_reg[cfg_index[CH_W-1:0]] = cfg_data;

            if (start && !busy)
            begin
                bin_sum = {1'b0, bin_first} + {1'b0, bin_second};
                // skip the term on an empty bin pair or a channel out of range
                if (bin_sum != 0 && channel < NUM_CHANNELS)
                begin
                    bin_diff = (bin_first >= bin_second) ? bin_first - bin_second
                                                         : bin_second - bin_first;
                    term = ((64'(bin_diff) * 64'(bin_diff)) << FRAC_BITS)
                           / (64'(bin_sum) << 16);
                    acc_next = 64'(chan_acc[channel]) + term;
                    chan_acc[channel] = (acc_next > 64'(ACC_MAX)) ? ACC_MAX
                                                                  : acc_next[ACC_W-1:0];
                end
                if (last_bin)
                begin
                    weighted = 0;
                    for (int c = 0; c < NUM_CHANNELS; c++)
                        if (c < NUM_WEIGHTS)
                            weighted += longint'(weight_reg[c]) * longint'({1'b0, chan_acc[c]});
                    // halve and drop the fraction, rounding toward minus infinity
                    floored = weighted >>> (FRAC_BITS + 1);
                    if (floored > SCORE_MAX)
                        floored = SCORE_MAX;
                    if (floored < SCORE_MIN)
                        floored = SCORE_MIN;
                    score_queue.insert(score_queue.size(), floored[OUT_W-1:0]);
                    for (int c = 0; c < NUM_CHANNELS; c++)
                        chan_acc[c] = '0;
                end
            end
            pending <= score_queue.size();
        end
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// Top of the chi-square weighted score bench: clock, reset, weight loads and
// histogram stimulus, watchdog and verdict. Depends on csws_pkg, the block
// and csws_score_checker.
module tb;

    import csws_pkg::*;

    localparam int NUM_CHANNELS   = 4;
    localparam int FRAC_BITS      = 16;
    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RAND_PHASES    = 10;
    localparam int PHASE_ITEMS    = 183;

    localparam logic [WGT_W-1:0] WGT_ZERO     = 24'h000000;
    localparam logic [WGT_W-1:0] WGT_ONE      = 24'h010000;
    localparam logic [WGT_W-1:0] WGT_NEG_HALF = 24'hFF8000;
    localparam logic [WGT_W-1:0] WGT_MAX      = 24'h7FFFFF;
    localparam logic [WGT_W-1:0] WGT_MIN      = 24'h800000;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [BIN_W-1:0]         bin_first;
    logic [BIN_W-1:0]         bin_second;
    logic [CH_W-1:0]          channel;
    logic                     last_bin;
    logic                     cfg_write;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [WGT_W-1:0]         cfg_data;
    logic                     done;
    logic signed [OUT_W-1:0]  pair_score;
    int                       mismatches;
    int                       pending;
    int                       idle_cycles;

    chi_square_weighted_score #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .FRAC_BITS    (FRAC_BITS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .bin_first      (bin_first),
        .bin_second     (bin_second),
        .channel        (channel),
        .last_bin       (last_bin),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .pair_score     (pair_score)
    );

    csws_score_checker #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .FRAC_BITS    (FRAC_BITS)
    ) i_score_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .bin_first      (bin_first),
        .bin_second     (bin_second),
        .channel        (channel),
        .last_bin       (last_bin),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .pair_score     (pair_score),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    initial
        clk = 1'b0;
    always #4 clk = ~clk;

    // End the run when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || cfg_write)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

    task automatic send_bin(input logic [BIN_W-1:0] a, input logic [BIN_W-1:0] b,
                            input logic [CH_W-1:0] ch, input logic last,
                            input bit idle_ok);
        start      <= 1'b1;
        bin_first  <= a;
        bin_second <= b;
        channel    <= ch;
        last_bin   <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // hold start high into the next transfer unless a gap is drawn
        if (idle_ok && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // let a trailing bin without last finish its division
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic load_weights(input logic [WGT_W-1:0] lum, input logic [WGT_W-1:0] ca,
                                input logic [WGT_W-1:0] cb, input logic [WGT_W-1:0] tex);
        cfg_write <= 1'b1;
        cfg_index <= REG_WEIGHT_LUM;
        cfg_data  <= lum;
        @(posedge clk);
        cfg_index <= REG_WEIGHT_CHROMA_A;
        cfg_data  <= ca;
        @(posedge clk);
        cfg_index <= REG_WEIGHT_CHROMA_B;
        cfg_data  <= cb;
        @(posedge clk);
        cfg_index <= REG_WEIGHT_TEXTURE;
        cfg_data  <= tex;
        @(posedge clk);
        // unused index, must leave the weights alone
        cfg_index <= CFG_IDX_W'($urandom_range(NUM_WEIGHTS, (1 << CFG_IDX_W) - 1));
        cfg_data  <= WGT_W'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_histograms(input int n_items, input bit idle_ok);
        int               sent;
        int               seq_len;
        bit               seq_gaps;
        logic [BIN_W-1:0] a;
        logic [BIN_W-1:0] b;
        logic [BIN_W-1:0] t;
        sent = 0;
        while (sent < n_items)
        begin
            seq_len  = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 14);
            seq_gaps = idle_ok && ($urandom_range(0, 9) < 7);
            for (int k = 0; k < seq_len; k++)
            begin
                a = BIN_W'($urandom_range(0, 16'hFFFF));
                b = BIN_W'($urandom_range(0, 16'hFFFF));
                case ($urandom_range(0, 7))
                    2: begin
                        a = BIN_W'($urandom_range(0, 15));
                        b = BIN_W'($urandom_range(0, 15));
                    end
                    3: b = a;
                    4: b = '0;
                    5: begin
                        a = '0;
                        b = '0;
                    end
                    6: begin
                        a = BIN_W'(16'hFFFF - $urandom_range(0, 255));
                        b = BIN_W'(16'hFFFF - $urandom_range(0, 255));
                    end
                    7: begin
                        a = BIN_W'($urandom_range(40000, 16'hFFFF));
                        b = BIN_W'($urandom_range(0, 100));
                    end
                    default: ;
                endcase
                if ($urandom_range(0, 1) == 1)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
                send_bin(a, b, CH_W'($urandom_range(0, 3)), k == seq_len - 1, seq_gaps);
            end
            sent += seq_len;
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        bin_first   = '0;
        bin_second  = '0;
        channel     = '0;
        last_bin    = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // weights straight out of reset, empty pair closing the histogram
        send_bin(16'h0000, 16'h0000, 2'd0, 1'b1, 1'b0);
        send_bin(16'hFFFF, 16'h1234, 2'd1, 1'b1, 1'b0);
        wait_quiet();

        load_weights(WGT_ONE, WGT_NEG_HALF, WGT_MAX, WGT_MIN);
        send_bin(16'hFFFF, 16'h0000, 2'd0, 1'b0, 1'b0);
        send_bin(16'h0000, 16'hFFFF, 2'd1, 1'b0, 1'b0);
        send_bin(16'hFFFF, 16'hFFFF, 2'd2, 1'b0, 1'b0);
        send_bin(16'h0001, 16'h0000, 2'd3, 1'b0, 1'b0);
        send_bin(16'h0000, 16'h0000, 2'd0, 1'b0, 1'b0);
        send_bin(16'h0000, 16'h0000, 2'd1, 1'b1, 1'b0);
        send_bin(16'hFFFF, 16'h0001, 2'd2, 1'b1, 1'b0);
        send_bin(16'h8000, 16'h7FFF, 2'd3, 1'b0, 1'b1);
        send_bin(16'hAAAA, 16'h5555, 2'd0, 1'b0, 1'b1);
        send_bin(16'h5555, 16'hAAAA, 2'd1, 1'b1, 1'b1);
        for (int c = 0; c < NUM_CHANNELS; c++)
            send_bin(16'd12345, 16'd54321, CH_W'(c), c == NUM_CHANNELS - 1, 1'b1);
        // bin without last; its channel sum carries into the next phase
        send_bin(16'hFFFF, 16'h0000, 2'd3, 1'b0, 1'b0);
        wait_quiet();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0: load_weights(WGT_MAX, WGT_MAX, WGT_MAX, WGT_MAX);
                1: load_weights(WGT_MIN, WGT_MIN, WGT_MIN, WGT_MIN);
                2: load_weights(WGT_MAX, WGT_MIN, WGT_MAX, WGT_MIN);
                3: load_weights(WGT_ZERO, WGT_ZERO, WGT_ZERO, WGT_ONE);
                default: load_weights(WGT_W'($urandom_range(0, 24'hFFFFFF)),
                                      WGT_W'($urandom_range(0, 24'hFFFFFF)),
                                      WGT_W'($urandom_range(0, 24'hFFFFFF)),
                                      WGT_W'($urandom_range(0, 24'hFFFFFF)));
            endcase
            // no gaps in the closing phase
            run_histograms(PHASE_ITEMS, ph != RAND_PHASES - 1);
            wait_quiet();
        end

        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* chi_square_weighted_score.f */
+incdir+rtl
rtl/csws_pkg.sv
rtl/csws_div.sv
rtl/csws_mac.sv
rtl/chi_square_weighted_score.sv
rtl/csws_checker.sv
bench/csws_score_checker.sv
bench/tb.sv
